// ----- sv/avg_pkg.sv -----
`timescale 1ns / 1ps
package avg_pkg;

  localparam int SEG_W          = 7;
  localparam int COORD_W        = 24;
  localparam int RADIUS_W       = 23;
  localparam int START_W        = 16;
  localparam int SWEEP_W        = 17;
  localparam int PHASE_W        = 32;
  localparam int DIVD_W         = PHASE_W + 1;
  localparam int CORDIC_W       = 34;
  localparam int CORDIC_ITERS   = 30;
  localparam int QUEUE_DEPTH    = 2;
  localparam int DEF_MAX_SEGMENTS = 64;
  localparam int DEF_ANGLE_BITS   = 16;

  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN_INV = 34'sd652032874;
  localparam logic signed [CORDIC_W-1:0] Q30_ONE         = 34'sd1073741824;
  localparam logic signed [31:0]         HALF_PI_Q30     = 32'sd1686629713;

  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [RADIUS_W-1:0]       r;
    logic [PHASE_W-1:0]        start_phase;
    logic [PHASE_W-1:0]        step_phase;
    logic [SEG_W-1:0]          n;
  } job_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

  typedef enum logic [3:0] {
    B_IDLE, B_ZMUL, B_ZLOAD, B_CORDIC, B_TRIG, B_SMUL0, B_SMUL1, B_SMUL2,
    B_EMIT, B_ROT0, B_ROT1, B_ROT2, B_ROT3, B_ROT4
  } back_state_t;

  function automatic logic signed [CORDIC_W-1:0] cordic_atan(input logic [4:0] i);
    logic signed [CORDIC_W-1:0] a;
    unique case (i)
      5'd0:  a = 34'sd843314857;
      5'd1:  a = 34'sd497837829;
      5'd2:  a = 34'sd263043837;
      5'd3:  a = 34'sd133525159;
      5'd4:  a = 34'sd67021687;
      5'd5:  a = 34'sd33543516;
      5'd6:  a = 34'sd16775851;
      5'd7:  a = 34'sd8388437;
      5'd8:  a = 34'sd4194283;
      5'd9:  a = 34'sd2097149;
      5'd10: a = 34'sd1048576;
      5'd11: a = 34'sd524288;
      default: a = 34'sd1 <<< (5'd30 - i);
    endcase
    return a;
  endfunction

endpackage

// ----- sv/avg_in_if.sv -----
`timescale 1ns / 1ps
interface avg_in_if;
  import avg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  center_x;
  logic signed [COORD_W-1:0]  center_y;
  logic [RADIUS_W-1:0]        radius;
  logic [START_W-1:0]         arc_start;
  logic [SWEEP_W-1:0]         sweep_angle;
  logic [SEG_W-1:0]           segment_count;
  modport source (output valid, center_x, center_y, radius, arc_start,
                  sweep_angle, segment_count, input ready);
  modport sink (input valid, center_x, center_y, radius, arc_start,
                sweep_angle, segment_count, output ready);
endinterface

// ----- sv/avg_out_if.sv -----
`timescale 1ns / 1ps
interface avg_out_if;
  import avg_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [COORD_W-1:0]  vertex_x;
  logic signed [COORD_W-1:0]  vertex_y;
  logic                       last_vertex;
  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

// ----- sv/avg_front.sv -----
`timescale 1ns / 1ps
module avg_front #(
  parameter int MAX_SEGMENTS = avg_pkg::DEF_MAX_SEGMENTS,
  parameter int ANGLE_BITS   = avg_pkg::DEF_ANGLE_BITS
) (
  input  logic          clk,
  input  logic          rst_n,
  avg_in_if.sink        in_chan,
  output avg_pkg::job_t q_wdata,
  output logic          q_push,
  input  logic          q_full
);
  import avg_pkg::*;

  localparam int SH = PHASE_W - ANGLE_BITS;
  localparam logic [63:0] ANG_MASK  = (64'd1 << ANGLE_BITS) - 64'd1;
  localparam logic [63:0] FULL_TURN = 64'd1 << ANGLE_BITS;
  localparam logic [SEG_W-1:0] MAX_N = SEG_W'(MAX_SEGMENTS);
  localparam logic [5:0] DIV_LAST = 6'(DIVD_W - 1);

  front_state_t state_r, state_nxt;
  job_t             job_r;
  logic [DIVD_W-1:0] dvd_r;
  logic [SEG_W-1:0]  rem_r;
  logic [SEG_W-1:0]  d_r;
  logic [5:0]        cnt_r;

  logic              acc;
  logic [SEG_W-1:0]  n_c;
  logic [63:0]       swp_c;
  logic [63:0]       dvd_full;
  logic [63:0]       st_full;
  logic [SEG_W:0]    rem_sh;
  logic              ge;

  assign acc      = in_chan.valid && in_chan.ready;
  assign n_c      = (in_chan.segment_count > MAX_N) ? MAX_N : in_chan.segment_count;
  assign swp_c    = (64'(in_chan.sweep_angle) > FULL_TURN) ? FULL_TURN
                                                           : 64'(in_chan.sweep_angle);
  assign dvd_full = swp_c << SH;
  assign st_full  = (64'(in_chan.arc_start) & ANG_MASK) << SH;
  assign rem_sh   = {rem_r, dvd_r[DIVD_W-1]};
  assign ge       = rem_sh >= {1'b0, d_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (acc && in_chan.segment_count != '0) begin
          state_nxt = (n_c == SEG_W'(1)) ? F_PUSH : F_DIV;
        end
      end
      F_DIV: begin
        if (cnt_r == DIV_LAST) state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (!q_full) state_nxt = F_IDLE;
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_chan.ready = (state_r == F_IDLE);
    q_push        = (state_r == F_PUSH) && !q_full;
    q_wdata       = job_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      F_IDLE: begin
        if (acc) begin
          job_r.cx          <= in_chan.center_x;
          job_r.cy          <= in_chan.center_y;
          job_r.r           <= in_chan.radius;
          job_r.start_phase <= st_full[PHASE_W-1:0];
          job_r.step_phase  <= '0;
          job_r.n           <= n_c;
          dvd_r             <= dvd_full[DIVD_W-1:0];
          d_r               <= n_c - SEG_W'(1);
          rem_r             <= '0;
          cnt_r             <= '0;
        end
      end
      F_DIV: begin
        rem_r <= ge ? SEG_W'(rem_sh - {1'b0, d_r}) : rem_sh[SEG_W-1:0];
        dvd_r <= {dvd_r[DIVD_W-2:0], ge};
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == DIV_LAST) begin
          job_r.step_phase <= {dvd_r[PHASE_W-2:0], ge};
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/avg_queue.sv -----
`timescale 1ns / 1ps
module avg_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  avg_pkg::job_t wdata,
  input  logic          push,
  output logic          full,
  output avg_pkg::job_t rdata,
  input  logic          pop,
  output logic          empty
);
  import avg_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  job_t          mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + PW'(1);
      if (pop)  rp_r <= rp_r + PW'(1);
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

endmodule

// ----- sv/avg_back.sv -----
`timescale 1ns / 1ps
module avg_back #(
  parameter int MAX_SEGMENTS = avg_pkg::DEF_MAX_SEGMENTS
) (
  input  logic          clk,
  input  logic          rst_n,
  input  avg_pkg::job_t q_rdata,
  input  logic          q_empty,
  output logic          q_pop,
  avg_out_if.source     out_chan
);
  import avg_pkg::*;

  localparam int KW = $clog2(MAX_SEGMENTS);

  back_state_t state_r, state_nxt;
  job_t                       job_r;
  logic                       sel_r;
  logic signed [CORDIC_W-1:0] cx_r, cy_r, cz_r;
  logic [4:0]                 it_r;
  logic signed [31:0]         sc_r, ss_r, rc_r, rs_r;
  logic signed [31:0]         x_r, y_r, nx_r;
  logic signed [63:0]         prod_r, acc_r;
  logic [KW-1:0]              k_r;
  logic                       out_valid_r;
  logic signed [COORD_W-1:0]  vx_r, vy_r;
  logic                       last_r;

  logic signed [31:0]         mul_a, mul_b;
  logic signed [63:0]         prod;
  logic                       out_load;
  logic [PHASE_W-1:0]         tphase;
  logic signed [CORDIC_W-1:0] atan_i, dx, dy, clx, cly;
  logic signed [31:0]         c_q, s_q;
  logic                       is_last;
  logic [SEG_W-1:0]           n_m1;
  logic signed [34:0]         vx_sum, vy_sum;
  logic signed [63:0]         rnd22, rnd30a, rnd30b;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] o;
    if (v > 64'sd2147483647)       o = 32'sh7fffffff;
    else if (v < -64'sd2147483648) o = 32'sh80000000;
    else                           o = v[31:0];
    return o;
  endfunction

  function automatic logic signed [COORD_W-1:0] sat24(input logic signed [34:0] v);
    logic signed [COORD_W-1:0] o;
    if (v > 35'sd8388607)       o = 24'sh7fffff;
    else if (v < -35'sd8388608) o = 24'sh800000;
    else                        o = v[COORD_W-1:0];
    return o;
  endfunction

  function automatic logic signed [CORDIC_W-1:0] clampq30(
      input logic signed [CORDIC_W-1:0] v);
    logic signed [CORDIC_W-1:0] o;
    if (v > Q30_ONE)       o = Q30_ONE;
    else if (v < -Q30_ONE) o = -Q30_ONE;
    else                   o = v;
    return o;
  endfunction

  function automatic logic signed [34:0] vertex_sum(input logic signed [31:0] p,
      input logic signed [COORD_W-1:0] c, input logic [RADIUS_W-1:0] r);
    logic signed [34:0] t;
    t = ($signed(35'(p)) + 35'sd128) >>> 8;
    return t + $signed(35'(c)) + $signed(35'(r));
  endfunction

  assign tphase = sel_r ? job_r.step_phase : job_r.start_phase;
  assign atan_i = cordic_atan(it_r);
  assign dx     = cy_r >>> it_r;
  assign dy     = cx_r >>> it_r;
  assign clx    = clampq30(cx_r);
  assign cly    = clampq30(cy_r);
  assign prod   = mul_a * mul_b;
  assign n_m1   = job_r.n - SEG_W'(1);
  assign is_last = (k_r == n_m1[KW-1:0]);
  assign vx_sum = vertex_sum(x_r, job_r.cx, job_r.r);
  assign vy_sum = vertex_sum(y_r, job_r.cy, job_r.r);
  assign rnd22  = (prod_r + 64'sd2097152) >>> 22;
  assign rnd30a = (acc_r - prod_r + 64'sd536870912) >>> 30;
  assign rnd30b = (acc_r + prod_r + 64'sd536870912) >>> 30;

  always_comb begin
    unique case (tphase[31:30])
      2'd0: begin c_q = clx[31:0];  s_q = cly[31:0];  end
      2'd1: begin c_q = -cly[31:0]; s_q = clx[31:0];  end
      2'd2: begin c_q = -clx[31:0]; s_q = -cly[31:0]; end
      default: begin c_q = cly[31:0]; s_q = -clx[31:0]; end
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (!q_empty) state_nxt = B_ZMUL;
      B_ZMUL:   state_nxt = B_ZLOAD;
      B_ZLOAD:  state_nxt = B_CORDIC;
      B_CORDIC: if (it_r == 5'(CORDIC_ITERS - 1)) state_nxt = B_TRIG;
      B_TRIG:   state_nxt = sel_r ? B_SMUL0 : B_ZMUL;
      B_SMUL0:  state_nxt = B_SMUL1;
      B_SMUL1:  state_nxt = B_SMUL2;
      B_SMUL2:  state_nxt = B_EMIT;
      B_EMIT:   if (out_load) state_nxt = is_last ? B_IDLE : B_ROT0;
      B_ROT0:   state_nxt = B_ROT1;
      B_ROT1:   state_nxt = B_ROT2;
      B_ROT2:   state_nxt = B_ROT3;
      B_ROT3:   state_nxt = B_ROT4;
      B_ROT4:   state_nxt = B_EMIT;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop    = (state_r == B_IDLE) && !q_empty;
    out_load = (state_r == B_EMIT) && (!out_valid_r || out_chan.ready);
    mul_a    = x_r;
    mul_b    = rc_r;
    unique case (state_r)
      B_ZMUL:  begin mul_a = $signed({2'b00, tphase[29:0]}); mul_b = HALF_PI_Q30; end
      B_SMUL0: begin mul_a = $signed(32'(job_r.r)); mul_b = sc_r; end
      B_SMUL1: begin mul_a = $signed(32'(job_r.r)); mul_b = ss_r; end
      B_ROT1:  begin mul_a = y_r; mul_b = rs_r; end
      B_ROT2:  begin mul_a = y_r; mul_b = rc_r; end
      B_ROT3:  begin mul_a = x_r; mul_b = rs_r; end
      default: begin mul_a = x_r; mul_b = rc_r; end
    endcase
    out_chan.valid       = out_valid_r;
    out_chan.vertex_x    = vx_r;
    out_chan.vertex_y    = vy_r;
    out_chan.last_vertex = last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load)                         out_valid_r <= 1'b1;
      else if (out_chan.ready)              out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod;
    if (out_load) begin
      vx_r   <= sat24(vx_sum);
      vy_r   <= sat24(vy_sum);
      last_r <= is_last;
    end
    unique case (state_r)
      B_IDLE: begin
        if (!q_empty) begin
          job_r <= q_rdata;
          sel_r <= 1'b0;
        end
      end
      B_ZLOAD: begin
        cz_r <= $signed({2'b00, prod_r[61:30]});
        cx_r <= CORDIC_GAIN_INV;
        cy_r <= '0;
        it_r <= '0;
      end
      B_CORDIC: begin
        it_r <= it_r + 5'd1;
        if (cz_r >= 0) begin
          cx_r <= cx_r - dx;
          cy_r <= cy_r + dy;
          cz_r <= cz_r - atan_i;
        end else begin
          cx_r <= cx_r + dx;
          cy_r <= cy_r - dy;
          cz_r <= cz_r + atan_i;
        end
      end
      B_TRIG: begin
        if (sel_r) begin
          rc_r <= c_q;
          rs_r <= s_q;
        end else begin
          sc_r <= c_q;
          ss_r <= s_q;
        end
        sel_r <= 1'b1;
      end
      B_SMUL1: x_r <= sat32(rnd22);
      B_SMUL2: begin
        y_r <= sat32(rnd22);
        k_r <= '0;
      end
      B_EMIT: if (out_load && !is_last) k_r <= k_r + KW'(1);
      B_ROT1:  acc_r <= prod_r;
      B_ROT2:  nx_r  <= sat32(rnd30a);
      B_ROT3:  acc_r <= prod_r;
      B_ROT4: begin
        x_r <= nx_r;
        y_r <= sat32(rnd30b);
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- sv/arc_vertex_generator.sv -----
`timescale 1ns / 1ps
// arc vertex generator: one request gives segment_count vertices along a circular arc,
// the last one flagged. the front stage clamps the request and divides the sweep by
// count - 1, one quotient bit a cycle, then hands the job through a two-entry queue,
// so it takes the next request while the back stage works. the back stage runs a
// 30-step cordic twice (start and step angle), then one shared 32x32 multiplier
// gives the start point and then each further vertex (four products a rotation).
// a result waiting in the output register does not hold up the front stage. a
// request with a count of zero gives no item.
module arc_vertex_generator #(
  parameter int MAX_SEGMENTS = avg_pkg::DEF_MAX_SEGMENTS,
  parameter int ANGLE_BITS   = avg_pkg::DEF_ANGLE_BITS
) (
  input  logic       clk,
  input  logic       rst_n,
  avg_in_if.sink     in_chan,
  avg_out_if.source  out_chan
);
  import avg_pkg::*;

  job_t q_wdata, q_rdata;
  logic q_push, q_full, q_pop, q_empty;

  avg_front #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ANGLE_BITS   (ANGLE_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .q_wdata (q_wdata),
    .q_push  (q_push),
    .q_full  (q_full)
  );

  avg_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wdata (q_wdata),
    .push  (q_push),
    .full  (q_full),
    .rdata (q_rdata),
    .pop   (q_pop),
    .empty (q_empty)
  );

  avg_back #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_rdata  (q_rdata),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full) else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty) else $error("queue read while empty");

  a_push_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (q_push && !q_pop) |=> !q_empty) else $error("pushed item lost");

endmodule
